FILE: rtl/cbpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpid_pkg
// Shared constants and a helper for the cascaded balance controller: mode
// codes, register indexes, gain reset values, reciprocal constants and
// fixed-point limits.
// ----------------------------------------------------------------------------
package cbpid_pkg;

  // supervisor modes (any other code runs as normal)
  localparam logic [1:0] MODE_BRAKE   = 2'd1;
  localparam logic [1:0] MODE_ISOLATE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 3'd4;

  // gain reset values, unsigned Q8.8
  localparam logic [15:0] RST_INNER_KP = 16'd7680;
  localparam logic [15:0] RST_INNER_KI = 16'd640;
  localparam logic [15:0] RST_INNER_KD = 16'd640;
  localparam logic [15:0] RST_OUTER_KP = 16'd461;
  localparam logic [15:0] RST_OUTER_KI = 16'd38;

  // ceil(2^18 / 5): exact floor(a / 5) for a below 2^18
  localparam logic [31:0] RECIP_5   = 32'd52429;
  // ceil(2^38 / 125): exact floor(n / 125) for n below 2^31
  localparam logic [31:0] RECIP_125 = 32'd2199023256;
  // slope scale (divide by 0.004) and steering scale (16 * 150)
  localparam logic [31:0] SLOPE_SCALE = 32'd250;
  localparam logic [31:0] STEER_SCALE = 32'd2400;

  // Q16.16 limits
  localparam logic signed [23:0] OINT_LIM  = 24'sd327680;    // 5.0
  localparam logic signed [43:0] ANGLE_LIM = 44'sd983040;    // 15.0 degrees
  localparam logic signed [15:0] TILT_LIM  = 16'sd11520;     // 45.0 degrees, Q8.8
  localparam logic signed [32:0] SAT33_HI  = 33'sd2147483647;
  localparam logic signed [32:0] SAT33_LO  = -33'sd2147483648;
  localparam logic signed [43:0] SAT44_HI  = 44'sd2147483647;
  localparam logic signed [43:0] SAT44_LO  = -44'sd2147483648;

  // floor(r * 2048 / 5) for a remainder r of a division by 5
  function automatic logic [10:0] div5_frac(input logic [2:0] r);
    logic [10:0] f;
    case (r)
      3'd1:    f = 11'd409;
      3'd2:    f = 11'd819;
      3'd3:    f = 11'd1228;
      3'd4:    f = 11'd1638;
      default: f = 11'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cascaded_balance_pid_core.sv
`timescale 1ns / 1ps
`default_nettype none
// One item is processed at a time: a normal item runs the whole sequence, a tilt
// fault ends after the lean angle and isolate mode goes straight to the output;
// ready returns the cycle after the output transfer.
// The schedule is set by one shared 32x32 multiplier that forms ten products in
// sequence (velocity scale, two divides by 250, five gains, slope, steering).
// Reset loads the default gains and clears all integrators and held outputs.
// ----------------------------------------------------------------------------
// cascaded_balance_pid_core
// Two-wheel balance controller: outer velocity PI giving a lean angle, inner
// pitch PID giving a drive, then direction and left/right PWM with steering.
// All multiplications run sign-magnitude through one multiplier under a sequencer.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_core
  import cbpid_pkg::*;
#(
  parameter int unsigned PWM_MAX = 999
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic signed [15:0]   left_count_i,
  input  wire logic signed [15:0]   right_count_i,
  input  wire logic signed [15:0]   tilt_angle_i,
  input  wire logic                 tilt_valid_i,
  input  wire logic signed [15:0]   target_speed_i,
  input  wire logic signed [15:0]   target_turn_rate_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [9:0]                pwm_left_o,
  output logic [9:0]                pwm_right_o,
  output logic                      reverse_dir_o,
  output logic                      standby_enable_o,
  output logic                      imu_fault_o
);

  localparam logic [17:0] PWM_CAP = 18'(PWM_MAX);

  typedef enum logic [4:0] {
    S_IDLE, S_VEL_MUL, S_VEL_FIX, S_ERR, S_OI_MUL, S_OKP_MUL, S_OKI_MUL,
    S_ANGLE, S_IERR, S_II_MUL, S_SLP_MUL, S_KP_MUL, S_KI_MUL, S_KD_MUL,
    S_DRV, S_PWM, S_OUT
  } state_e;

  // integer part of a Q18.16 value, zero if not positive, capped at PWM_MAX
  function automatic logic [9:0] to_pwm(input logic signed [33:0] v);
    logic [17:0] p;
    p = v[33:16];
    if (v <= 0) return 10'd0;
    if (p > PWM_CAP) return PWM_CAP[9:0];
    return p[9:0];
  endfunction

  state_e state_q;

  // gains
  logic [15:0] inner_kp_q, inner_ki_q, inner_kd_q, outer_kp_q, outer_ki_q;

  // captured item
  logic signed [16:0] sum_q;
  logic signed [15:0] tspeed_q, tturn_q, tilt_q;
  logic               tilt_fault_q;

  // working values
  logic [63:0]        prod_q;
  logic               prod_neg_q;
  logic signed [27:0] vel_q;
  logic signed [28:0] verr_q;
  logic signed [43:0] acc_q;
  logic signed [20:0] angle_q;
  logic signed [22:0] ierr_q;
  logic signed [23:0] dif_q;
  logic [31:0]        slope_mag_q;
  logic               slope_neg_q;
  logic signed [31:0] drive_q;

  // loop state
  logic signed [19:0] outer_int_q;
  logic signed [31:0] inner_int_q;
  logic signed [22:0] prev_err_q;
  logic [9:0]         held_left_q, held_right_q;
  logic               held_dir_q;

  // result registers
  logic [9:0] pwm_left_q, pwm_right_q;
  logic       reverse_q, standby_q, imu_fault_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_kp_q <= RST_INNER_KP;
      inner_ki_q <= RST_INNER_KI;
      inner_kd_q <= RST_INNER_KD;
      outer_kp_q <= RST_OUTER_KP;
      outer_ki_q <= RST_OUTER_KI;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INNER_KP: inner_kp_q <= cfg_data_i;
        REG_INNER_KI: inner_ki_q <= cfg_data_i;
        REG_INNER_KD: inner_kd_q <= cfg_data_i;
        REG_OUTER_KP: outer_kp_q <= cfg_data_i;
        REG_OUTER_KI: outer_ki_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // magnitudes
  logic [16:0] sum_abs;
  logic [28:0] verr_abs;
  logic [19:0] oint_abs;
  logic [22:0] ierr_abs;
  logic [23:0] dif_abs;
  logic [31:0] iint_abs;
  logic [15:0] tturn_abs;
  logic [31:0] drive_abs;

  assign sum_abs   = sum_q[16]       ? 17'(-sum_q)       : 17'(sum_q);
  assign verr_abs  = verr_q[28]      ? 29'(-verr_q)      : 29'(verr_q);
  assign oint_abs  = outer_int_q[19] ? 20'(-outer_int_q) : 20'(outer_int_q);
  assign ierr_abs  = ierr_q[22]      ? 23'(-ierr_q)      : 23'(ierr_q);
  assign dif_abs   = dif_q[23]       ? 24'(-dif_q)       : 24'(dif_q);
  assign iint_abs  = inner_int_q[31] ? 32'(-inner_int_q) : 32'(inner_int_q);
  assign tturn_abs = tturn_q[15]     ? 16'(-tturn_q)     : 16'(tturn_q);
  assign drive_abs = drive_q[31]     ? 32'(-drive_q)     : 32'(drive_q);

  // velocity: (l + r) * 6144 / 5 as 2048 * floor(3|s| / 5) plus a remainder table
  logic [17:0] vel_a;
  logic [15:0] vel_qa;
  logic [17:0] vel_rem;
  logic [26:0] vel_mag;

  assign vel_a   = {sum_abs, 1'b0} + {1'b0, sum_abs};
  assign vel_qa  = prod_q[33:18];
  assign vel_rem = vel_a - ({vel_qa, 2'b00} + {2'b00, vel_qa});
  assign vel_mag = {vel_qa, 11'b0} + {16'b0, div5_frac(vel_rem[2:0])};

  // signed views of the product: gain term (/256), quotient (/250) and steering term
  logic [39:0]        term_mag;
  logic signed [41:0] term_s;
  logic [21:0]        quo_mag;
  logic signed [22:0] quo_s;
  logic signed [27:0] steer_s;

  assign term_mag = prod_q[47:8];
  assign term_s   = prod_neg_q ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
  assign quo_mag  = prod_q[59:38];
  assign quo_s    = prod_neg_q ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
  assign steer_s  = prod_neg_q ? -$signed({1'b0, prod_q[26:0]})
                               : $signed({1'b0, prod_q[26:0]});

  // integrator, angle and drive updates
  logic signed [23:0] oint_sum;
  logic signed [19:0] outer_int_d;
  logic signed [43:0] ang_sum;
  logic signed [20:0] angle_d;
  logic signed [32:0] iint_sum;
  logic signed [31:0] inner_int_d;
  logic signed [43:0] drv_sum;
  logic signed [31:0] drive_d;
  logic signed [28:0] verr_d;
  logic signed [24:0] ierr_wide;
  logic signed [33:0] drive_mag;
  logic signed [33:0] left_sum, right_sum;

  assign oint_sum  = {{4{outer_int_q[19]}}, outer_int_q} + {quo_s[22], quo_s};
  assign ang_sum   = acc_q + {{2{term_s[41]}}, term_s};
  assign iint_sum  = {inner_int_q[31], inner_int_q} + {{10{quo_s[22]}}, quo_s};
  assign drv_sum   = acc_q + {{2{term_s[41]}}, term_s};
  assign verr_d    = {{9{tspeed_q[15]}}, tspeed_q, 4'b0} - {vel_q[27], vel_q};
  assign ierr_wide = {{4{angle_q[20]}}, angle_q} - {tilt_q[15], tilt_q, 8'b0};
  assign drive_mag = {2'b00, drive_abs};
  assign left_sum  = drive_mag + {{6{steer_s[27]}}, steer_s};
  assign right_sum = drive_mag - {{6{steer_s[27]}}, steer_s};

  always_comb begin
    // outer integrator clamp
    if (oint_sum > OINT_LIM)       outer_int_d = 20'(OINT_LIM);
    else if (oint_sum < -OINT_LIM) outer_int_d = 20'(-OINT_LIM);
    else                           outer_int_d = oint_sum[19:0];
    // lean angle clamp
    if (ang_sum > ANGLE_LIM)       angle_d = 21'(ANGLE_LIM);
    else if (ang_sum < -ANGLE_LIM) angle_d = 21'(-ANGLE_LIM);
    else                           angle_d = ang_sum[20:0];
    // inner integrator saturation
    if (iint_sum > SAT33_HI)       inner_int_d = 32'(SAT33_HI);
    else if (iint_sum < SAT33_LO)  inner_int_d = 32'(SAT33_LO);
    else                           inner_int_d = iint_sum[31:0];
    // drive saturation
    if (drv_sum > SAT44_HI)        drive_d = 32'(SAT44_HI);
    else if (drv_sum < SAT44_LO)   drive_d = 32'(SAT44_LO);
    else                           drive_d = drv_sum[31:0];
  end

  // shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;
  logic [63:0] mul_p;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state_q)
      S_VEL_MUL: begin
        mul_a = RECIP_5;
        mul_b = {14'b0, vel_a};
      end
      S_OI_MUL: begin
        mul_a   = RECIP_125;
        mul_b   = {4'b0, verr_abs[28:1]};
        mul_neg = verr_q[28];
      end
      S_OKP_MUL: begin
        mul_a   = {16'b0, outer_kp_q};
        mul_b   = {3'b0, verr_abs};
        mul_neg = verr_q[28];
      end
      S_OKI_MUL: begin
        mul_a   = {16'b0, outer_ki_q};
        mul_b   = {12'b0, oint_abs};
        mul_neg = outer_int_q[19];
      end
      S_II_MUL: begin
        mul_a   = RECIP_125;
        mul_b   = {10'b0, ierr_abs[22:1]};
        mul_neg = ierr_q[22];
      end
      S_SLP_MUL: begin
        mul_a   = SLOPE_SCALE;
        mul_b   = {8'b0, dif_abs};
        mul_neg = dif_q[23];
      end
      S_KP_MUL: begin
        mul_a   = {16'b0, inner_kp_q};
        mul_b   = {9'b0, ierr_abs};
        mul_neg = ierr_q[22];
      end
      S_KI_MUL: begin
        mul_a   = {16'b0, inner_ki_q};
        mul_b   = iint_abs;
        mul_neg = inner_int_q[31];
      end
      S_KD_MUL: begin
        mul_a   = {16'b0, inner_kd_q};
        mul_b   = slope_mag_q;
        mul_neg = slope_neg_q;
      end
      S_DRV: begin
        mul_a   = STEER_SCALE;
        mul_b   = {16'b0, tturn_abs};
        mul_neg = tturn_q[15];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sequencer, datapath registers and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      tspeed_q     <= '0;
      tturn_q      <= '0;
      tilt_q       <= '0;
      tilt_fault_q <= 1'b0;
      prod_q       <= '0;
      prod_neg_q   <= 1'b0;
      vel_q        <= '0;
      verr_q       <= '0;
      acc_q        <= '0;
      angle_q      <= '0;
      ierr_q       <= '0;
      dif_q        <= '0;
      slope_mag_q  <= '0;
      slope_neg_q  <= 1'b0;
      drive_q      <= '0;
      outer_int_q  <= '0;
      inner_int_q  <= '0;
      prev_err_q   <= '0;
      held_left_q  <= '0;
      held_right_q <= '0;
      held_dir_q   <= 1'b0;
      pwm_left_q   <= '0;
      pwm_right_q  <= '0;
      reverse_q    <= 1'b0;
      standby_q    <= 1'b0;
      imu_fault_q  <= 1'b0;
    end else begin
      prod_q     <= mul_p;
      prod_neg_q <= mul_neg;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sum_q        <= {left_count_i[15], left_count_i}
                          + {right_count_i[15], right_count_i};
            tilt_q       <= tilt_angle_i;
            tilt_fault_q <= !tilt_valid_i || (tilt_angle_i > TILT_LIM)
                         || (tilt_angle_i < -TILT_LIM);
            // brake zeroes both targets
            tspeed_q     <= (mode_i == MODE_BRAKE) ? 16'sd0 : target_speed_i;
            tturn_q      <= (mode_i == MODE_BRAKE) ? 16'sd0 : target_turn_rate_i;
            if (mode_i == MODE_ISOLATE) begin
              held_left_q  <= '0;
              held_right_q <= '0;
              pwm_left_q   <= '0;
              pwm_right_q  <= '0;
              reverse_q    <= held_dir_q;
              standby_q    <= 1'b0;
              imu_fault_q  <= 1'b0;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_VEL_MUL;
            end
          end
        end
        S_VEL_MUL: state_q <= S_VEL_FIX;
        S_VEL_FIX: begin
          vel_q   <= sum_q[16] ? -$signed({1'b0, vel_mag}) : $signed({1'b0, vel_mag});
          state_q <= S_ERR;
        end
        S_ERR: begin
          verr_q  <= verr_d;
          state_q <= S_OI_MUL;
        end
        S_OI_MUL: state_q <= S_OKP_MUL;
        S_OKP_MUL: begin
          outer_int_q <= outer_int_d;
          state_q     <= S_OKI_MUL;
        end
        S_OKI_MUL: begin
          acc_q   <= {{2{term_s[41]}}, term_s};
          state_q <= S_ANGLE;
        end
        S_ANGLE: begin
          angle_q <= angle_d;
          if (tilt_fault_q) begin
            // hold previous drive, flag the fault
            pwm_left_q  <= held_left_q;
            pwm_right_q <= held_right_q;
            reverse_q   <= held_dir_q;
            standby_q   <= 1'b1;
            imu_fault_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_IERR;
          end
        end
        S_IERR: begin
          ierr_q  <= ierr_wide[22:0];
          state_q <= S_II_MUL;
        end
        S_II_MUL: begin
          dif_q      <= {ierr_q[22], ierr_q} - {prev_err_q[22], prev_err_q};
          prev_err_q <= ierr_q;
          state_q    <= S_SLP_MUL;
        end
        S_SLP_MUL: begin
          inner_int_q <= inner_int_d;
          state_q     <= S_KP_MUL;
        end
        S_KP_MUL: begin
          slope_mag_q <= prod_q[31:0];
          slope_neg_q <= prod_neg_q;
          state_q     <= S_KI_MUL;
        end
        S_KI_MUL: begin
          acc_q   <= {{2{term_s[41]}}, term_s};
          state_q <= S_KD_MUL;
        end
        S_KD_MUL: begin
          acc_q   <= ang_sum;
          state_q <= S_DRV;
        end
        S_DRV: begin
          drive_q <= drive_d;
          state_q <= S_PWM;
        end
        S_PWM: begin
          held_dir_q   <= drive_q[31];
          held_left_q  <= to_pwm(left_sum);
          held_right_q <= to_pwm(right_sum);
          pwm_left_q   <= to_pwm(left_sum);
          pwm_right_q  <= to_pwm(right_sum);
          reverse_q    <= drive_q[31];
          standby_q    <= 1'b1;
          imu_fault_q  <= 1'b0;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // handshake and result ports
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign pwm_left_o       = pwm_left_q;
  assign pwm_right_o      = pwm_right_q;
  assign reverse_dir_o    = reverse_q;
  assign standby_enable_o = standby_q;
  assign imu_fault_o      = imu_fault_q;

endmodule
`default_nettype wire
